>>> hdl/tra_pkg.sv
// tra_pkg: shared types and constants for the tile range allocator.
// Used by tra_engine and tile_range_allocator_top; depends on nothing.
package tra_pkg;

  localparam int MAX_RANGES   = 64;
  localparam int TILE_ID_BITS = 16;

  localparam logic [16:0] POOL_CAP =
    (TILE_ID_BITS >= 16) ? 17'h10000 : (17'd1 << TILE_ID_BITS);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] REG_POOL_ENABLED = 2'd0;
  localparam logic [1:0] REG_TILES_X      = 2'd1;
  localparam logic [1:0] REG_TILES_Y      = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OVERFLOW   = 3'd1,
    ST_FRAGMENTED = 3'd2,
    ST_NOT_READY  = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_FULL       = 3'd5,
    ST_ZERO       = 3'd6
  } status_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [15:0] first_tile;
    logic [16:0] free_tiles;
  } result_t;

endpackage

>>> hdl/tra_engine.sv
// tra_engine: range table memory and the scan/shift sequencer.
// Depends on tra_pkg.
module tra_engine #(
  parameter int MAX_RANGES = tra_pkg::MAX_RANGES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             op,
  input  logic [16:0]      tile_count,
  input  logic [15:0]      range_first,
  input  logic [15:0]      range_last,
  input  logic             pool_enabled,
  input  logic [16:0]      pool_size,
  output logic             idle,
  input  logic             res_ready,
  output tra_pkg::result_t res
);

  localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state;

  logic [31:0]      mem [MAX_RANGES];
  logic [31:0]      rd_data;
  logic [IW-1:0]    rd_idx;
  logic             we;
  logic [IW-1:0]    wa;
  logic [31:0]      wd;

  logic [CW-1:0]    count;
  logic [16:0]      total;
  logic             op_r;
  logic [16:0]      req_count;
  logic [15:0]      req_first;
  logic [15:0]      req_last;
  logic [CW-1:0]    scan_idx;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    p;
  logic             pend;
  logic [IW-1:0]    waddr;
  logic [16:0]      run_begin;
  logic [17:0]      run_end;
  tra_pkg::status_t status_r;
  logic [15:0]      first_r;

  logic [15:0]      e_first;
  logic [15:0]      e_last;
  logic [16:0]      free_now;
  logic             overlap;
  logic             fits;

  assign e_first  = rd_data[31:16];
  assign e_last   = rd_data[15:0];
  assign free_now = (pool_size > total) ? (pool_size - total) : 17'd0;
  assign overlap  = (run_begin <= {1'b0, e_last}) && ({2'b00, e_first} <= run_end);
  assign fits     = run_end < {1'b0, pool_size};
  assign idle     = (state == S_IDLE);

  always_comb begin
    rd_idx = '0;
    we     = 1'b0;
    wa     = waddr;
    wd     = rd_data;
    case (state)
      S_SCAN: rd_idx = IW'(scan_idx + CW'(1));
      S_SHIFT: begin
        if (pend) begin
          we = 1'b1;
        end
        if (op_r == tra_pkg::OP_ALLOC) begin
          if (p > pos) begin
            rd_idx = IW'(p - CW'(1));
          end else if (!pend) begin
            we = 1'b1;
            wa = IW'(pos);
            wd = {run_begin[15:0], run_end[15:0]};
          end
        end else if ((p + CW'(1)) < count) begin
          rd_idx = IW'(p + CW'(1));
        end
      end
      default: rd_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r      <= op;
            req_count <= tile_count;
            req_first <= range_first;
            req_last  <= range_last;
            scan_idx  <= '0;
            run_begin <= '0;
            run_end   <= {1'b0, tile_count} - 18'd1;
            pend      <= 1'b0;
            first_r   <= '0;
            state     <= S_SCAN;
            if (op == tra_pkg::OP_ALLOC) begin
              if (!pool_enabled) begin
                status_r <= tra_pkg::ST_NOT_READY;
                state    <= S_RESP;
              end else if (tile_count == 17'd0) begin
                status_r <= tra_pkg::ST_ZERO;
                state    <= S_RESP;
              end else if (count >= CW'(MAX_RANGES)) begin
                status_r <= tra_pkg::ST_FULL;
                state    <= S_RESP;
              end
            end
          end
        end
        S_SCAN: begin
          if (op_r == tra_pkg::OP_ALLOC) begin
            if (scan_idx != count && overlap) begin
              run_begin <= {1'b0, e_last} + 17'd1;
              run_end   <= {2'b00, e_last} + {1'b0, req_count};
              scan_idx  <= scan_idx + CW'(1);
            end else if (fits) begin
              pos   <= scan_idx;
              p     <= count;
              state <= S_SHIFT;
            end else begin
              status_r <= (free_now < req_count) ? tra_pkg::ST_OVERFLOW
                                                 : tra_pkg::ST_FRAGMENTED;
              state    <= S_RESP;
            end
          end else begin
            if (scan_idx == count) begin
              status_r <= tra_pkg::ST_NOT_FOUND;
              state    <= S_RESP;
            end else if (e_first == req_first && e_last == req_last) begin
              total <= total - ({1'b0, req_last - req_first} + 17'd1);
              p     <= scan_idx;
              state <= S_SHIFT;
            end else begin
              scan_idx <= scan_idx + CW'(1);
            end
          end
        end
        S_SHIFT: begin
          if (op_r == tra_pkg::OP_ALLOC) begin
            if (p > pos) begin
              pend  <= 1'b1;
              waddr <= IW'(p);
              p     <= p - CW'(1);
            end else if (pend) begin
              pend <= 1'b0;
            end else begin
              count    <= count + CW'(1);
              total    <= total + req_count;
              status_r <= tra_pkg::ST_OK;
              first_r  <= run_begin[15:0];
              state    <= S_RESP;
            end
          end else begin
            if ((p + CW'(1)) < count) begin
              pend  <= 1'b1;
              waddr <= IW'(p);
              p     <= p + CW'(1);
            end else if (pend) begin
              pend <= 1'b0;
            end else begin
              count    <= count - CW'(1);
              status_r <= tra_pkg::ST_OK;
              state    <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid      = (state == S_RESP);
  assign res.status     = status_r;
  assign res.first_tile = (status_r == tra_pkg::ST_OK) ? first_r : 16'd0;
  assign res.free_tiles = free_now;

endmodule

>>> hdl/tile_range_allocator_top.sv
// tile_range_allocator_top: configuration registers, pool size, result register.
// Depends on tra_pkg and tra_engine.
// Not ready, zero request and table full are answered without a table scan; otherwise the
// request scans and shifts the live entries through the table's single read port.
// Throughput: one request in flight; the next is taken once its result is queued.
// Reset: registers to defaults, table empty; table memory is not cleared.
module tile_range_allocator_top #(
  parameter int MAX_RANGES = tra_pkg::MAX_RANGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [16:0] tile_count,
  input  logic [15:0] range_first,
  input  logic [15:0] range_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] first_tile,
  output logic [16:0] free_tiles
);

  logic             pool_enabled;
  logic [8:0]       tiles_x;
  logic [8:0]       tiles_y;
  logic [8:0]       x_sat;
  logic [8:0]       y_sat;
  logic [17:0]      product;
  logic [16:0]      pool_size;
  logic             idle;
  logic             res_ready;
  tra_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_enabled <= 1'b0;
      tiles_x      <= 9'd128;
      tiles_y      <= 9'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        tra_pkg::REG_POOL_ENABLED: pool_enabled <= cfg_data[0];
        tra_pkg::REG_TILES_X:      tiles_x      <= cfg_data;
        tra_pkg::REG_TILES_Y:      tiles_y      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign x_sat     = (tiles_x > 9'd256) ? 9'd256 : tiles_x;
  assign y_sat     = (tiles_y > 9'd256) ? 9'd256 : tiles_y;
  assign product   = x_sat * y_sat;
  assign pool_size = (product > {1'b0, tra_pkg::POOL_CAP}) ? tra_pkg::POOL_CAP
                                                           : product[16:0];

  assign in_ready  = idle;
  assign res_ready = !out_valid || out_ready;

  tra_engine #(
    .MAX_RANGES(MAX_RANGES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .start       (in_valid && in_ready),
    .op          (op),
    .tile_count  (tile_count),
    .range_first (range_first),
    .range_last  (range_last),
    .pool_enabled(pool_enabled),
    .pool_size   (pool_size),
    .idle        (idle),
    .res_ready   (res_ready),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      status     <= res.status;
      first_tile <= res.first_tile;
      free_tiles <= res.free_tiles;
    end
  end

endmodule
